FILE: rtl/mhpq_pkg.sv
`timescale 1ns / 1ps
// Shared types for the min-heap priority queue: request and response
// structs, operation and status codes, and the cell control bundles.
// No dependencies.
package mhpq_pkg;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 8;

  // One request on the input channel
  typedef struct packed {
    kind_e                    kind;
    logic signed [ValueW-1:0] in_value;
  } req_t;

  // One response on the output channel
  typedef struct packed {
    logic signed [ValueW-1:0] out_value;
    status_e                  status;
    logic [CountW-1:0]        entry_count;
  } rsp_t;

  // Command broadcast to every cell in the same cycle
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [ValueW-1:0] value;
  } cmd_t;

  // Contents of one cell as seen by its neighbors
  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] value;
  } slot_t;

endpackage

FILE: rtl/mhpq_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted chain: holds a single entry and trades it with
// its neighbors on insert and remove. Depends on mhpq_pkg.
module mhpq_cell import mhpq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  slot_t left_i,
  input  logic  left_gt_i,
  input  slot_t right_i,
  output slot_t slot_o,
  output logic  gt_o
);

  logic                     valid_q, valid_d;
  logic signed [ValueW-1:0] value_q, value_d;

  // Flag whether the incoming value belongs at or before this cell
  assign gt_o   = !valid_q || (value_q > cmd_i.value);
  assign slot_o = '{valid: valid_q, value: value_q};

  // Shift right past the insertion point, or shift left on remove
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (cmd_i.ins) begin
      valid_d = valid_q | left_i.valid;
      if (left_gt_i) begin
        value_d = left_i.value;
      end else if (gt_o) begin
        value_d = cmd_i.value;
      end
    end else if (cmd_i.rem) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

FILE: rtl/min_heap_priority_queue.sv
`timescale 1ns / 1ps
// Min-priority queue of signed 32-bit values built as a sorted chain of
// CAPACITY cells, smallest at the head. Depends on mhpq_pkg and mhpq_cell.
//
// Each request is an insert or a remove-minimum and yields exactly one
// registered response, valid in the cycle after it is accepted. Every cell
// compares the new value with its own entry in parallel and hands its entry
// to a neighbor, so all cells move together and a new request is taken every
// cycle while the output side keeps up; the per-cell 32-bit compare sets the
// clock. A remove on an empty queue answers with empty status and value zero;
// an insert on a full queue answers with full status. Neither changes the
// contents. entry_count is the number held after the operation, low 8 bits.
// No clearing pass is needed after reset.
module min_heap_priority_queue import mhpq_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] FullCount = CntW'(CAPACITY);

  logic            accept;
  logic            is_full, is_empty;
  cmd_t            cmd;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  rsp_t            rsp_q, rsp_d;
  logic [CntW+CountW-1:0] count_ext;

  slot_t           slots [CAPACITY];
  logic            gts   [CAPACITY];

  // Take a request whenever the response register is free or draining
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & !in_stall_o;
  assign is_full    = (count_q == FullCount);
  assign is_empty   = (count_q == '0);

  // Broadcast the operation to the chain
  assign cmd.ins   = accept && (in_data_i.kind == KIND_INSERT) && !is_full;
  assign cmd.rem   = accept && (in_data_i.kind == KIND_REMOVE) && !is_empty;
  assign cmd.value = in_data_i.in_value;

  // Build the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t left_s, right_s;
    logic  left_gt;
    if (i == 0) begin : g_head
      assign left_s  = '{valid: 1'b1, value: '0};
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left_s  = slots[i-1];
      assign left_gt = gts[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_s = '{valid: 1'b0, value: '0};
    end else begin : g_next
      assign right_s = slots[i+1];
    end
    mhpq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    (left_s),
      .left_gt_i (left_gt),
      .right_i   (right_s),
      .slot_o    (slots[i]),
      .gt_o      (gts[i])
    );
  end

  // Advance the fill count and form the response
  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + 1'b1;
    end else if (cmd.rem) begin
      count_d = count_q - 1'b1;
    end
    count_ext         = {{CountW{1'b0}}, count_d};
    rsp_d.out_value   = '0;
    rsp_d.status      = ST_DONE;
    rsp_d.entry_count = count_ext[CountW-1:0];
    case (in_data_i.kind)
      KIND_INSERT: begin
        if (is_full) begin
          rsp_d.status = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        if (is_empty) begin
          rsp_d.status = ST_EMPTY;
        end else begin
          rsp_d.out_value = slots[0].value;
        end
      end
      default: begin
        rsp_d.status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the response until it is taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

endmodule

FILE: verif/min_heap_priority_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for min_heap_priority_queue: a heap predictor tracks every
// accepted request and each response is compared field by field.
// Depends on mhpq_pkg and the min_heap_priority_queue RTL.
module min_heap_priority_queue_tb;
  import mhpq_pkg::*;

  localparam int unsigned Capacity = 128;

  // One queued request, optionally held back until all responses are in
  typedef struct {
    req_t req;
    bit   drain_first;
  } pending_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;

  pending_t request_q[$];
  rsp_t     answer_q[$];

  // Predictor state: implicit binary heap
  logic signed [ValueW-1:0] heap_mem[Capacity];
  int unsigned              heap_fill = 0;

  int unsigned fail_count = 0;
  int unsigned plan_fill  = 0;
  int unsigned send_idle  = 0;
  int unsigned recv_idle  = 0;
  bit          send_calm  = 1'b0;
  bit          recv_calm  = 1'b0;

  min_heap_priority_queue #(
    .CAPACITY(Capacity)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Apply one request to the heap and return the response it should produce
  function automatic rsp_t heap_op_answer(req_t r);
    rsp_t                     a;
    int unsigned              pos;
    int unsigned              up;
    int unsigned              lc;
    int unsigned              pick;
    logic signed [ValueW-1:0] tmp;
    a.out_value = '0;
    a.status    = ST_DONE;
    if (r.kind == KIND_INSERT) begin
      if (heap_fill >= Capacity) begin
        a.status = ST_FULL;
      end else begin
        pos = heap_fill;
        heap_mem[pos] = r.in_value;
        heap_fill++;
        // sift up while the parent is greater
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(heap_mem[up] > heap_mem[pos])) break;
          tmp = heap_mem[up];
          heap_mem[up] = heap_mem[pos];
          heap_mem[pos] = tmp;
          pos = up;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        a.status = ST_EMPTY;
      end else begin
        a.out_value = heap_mem[0];
        heap_fill--;
        heap_mem[0] = heap_mem[heap_fill];
        // sift down toward the smaller child, left wins ties
        pos = 0;
        while (pos < heap_fill / 2) begin
          lc = 2 * pos + 1;
          pick = lc;
          if (lc + 1 < heap_fill && heap_mem[lc] > heap_mem[lc + 1]) pick = lc + 1;
          if (!(heap_mem[pos] > heap_mem[pick])) break;
          tmp = heap_mem[pos];
          heap_mem[pos] = heap_mem[pick];
          heap_mem[pick] = tmp;
          pos = pick;
        end
      end
    end
    a.entry_count = CountW'(heap_fill);
    return a;
  endfunction

  // Mostly short idle stretches, a few long ones, none while calm
  function automatic int unsigned idle_len(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Spread values over full range, small clustered values and both extremes
  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return $signed($urandom_range(0, 15)) - 8;
      8:          return 32'h7fff_ffff - $urandom_range(0, 3);
      default:    return 32'h8000_0000 + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic add_insert(logic signed [ValueW-1:0] v, bit drain);
    pending_t p;
    p.req.kind     = KIND_INSERT;
    p.req.in_value = v;
    p.drain_first  = drain;
    request_q.push_back(p);
    if (plan_fill < Capacity) plan_fill++;
  endtask

  task automatic add_remove(bit drain);
    pending_t p;
    p.req.kind     = KIND_REMOVE;
    p.req.in_value = $urandom;
    p.drain_first  = drain;
    request_q.push_back(p);
    if (plan_fill > 0) plan_fill--;
  endtask

  task automatic add_mix(int unsigned n, int unsigned insert_pct);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < insert_pct) add_insert(pick_value(), 1'b0);
      else add_remove(1'b0);
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Reset once at the start
  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: record accepted requests, then load the next one or idle
  always @(posedge clk_i or negedge rst_ni) begin
    pending_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) answer_q.push_back(heap_op_answer(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (send_idle > 0) begin
          send_idle--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (request_q[0].drain_first && answer_q.size() != 0) begin
          // hold off until every outstanding response is back
          in_valid_i <= 1'b0;
        end else begin
          nxt = request_q.pop_front();
          in_valid_i <= 1'b1;
          in_data_i  <= nxt.req;
          if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
          send_idle = idle_len(send_calm);
        end
      end
    end
  end

  // Monitor: check each accepted response, then stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          $error("response with no request outstanding");
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (out_data_o.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, out_data_o.out_value);
            fail_count++;
          end
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            fail_count++;
          end
          if (out_data_o.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_data_o.entry_count);
            fail_count++;
          end
        end
      end
      if (recv_idle > 0) begin
        recv_idle--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
        if ($urandom_range(0, 2) == 0) recv_idle = idle_len(recv_calm);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    // remove on empty, extremes, ties, drain past empty
    add_remove(1'b0);
    add_insert(32'h7fff_ffff, 1'b0);
    add_insert(32'h8000_0000, 1'b0);
    add_insert(0, 1'b0);
    add_insert(-1, 1'b0);
    add_insert(1, 1'b0);
    add_insert(5, 1'b0);
    add_insert(5, 1'b0);
    add_insert(5, 1'b0);
    add_insert(-1, 1'b0);
    for (int k = 0; k < 10; k++) add_remove(1'b0);
    add_insert(32'h8000_0000, 1'b0);
    add_insert(32'h8000_0000, 1'b0);
    add_remove(1'b0);
    add_remove(1'b0);

    // mixed traffic
    add_mix(80, 60);
    // fill to capacity and push past it
    add_insert(pick_value(), 1'b1);
    while (plan_fill < Capacity) add_insert(pick_value(), 1'b0);
    for (int k = 0; k < 3; k++) add_insert(pick_value(), 1'b0);
    add_mix(10, 50);
    // drain to empty and past it
    add_remove(1'b1);
    while (plan_fill > 0) add_remove(1'b0);
    add_remove(1'b0);
    add_remove(1'b0);
    // tail of mixed traffic
    add_mix(150, 55);

    while (request_q.size() != 0 || in_valid_i || answer_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: min_heap_priority_queue.f
rtl/mhpq_pkg.sv
rtl/mhpq_cell.sv
rtl/min_heap_priority_queue.sv
verif/min_heap_priority_queue_tb.sv
